/* hw/rtl/midpoint_subdivision_line_clip_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers for the line clipper, removable with ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef MIDPOINT_SUBDIVISION_LINE_CLIP_MACROS_SVH
`define MIDPOINT_SUBDIVISION_LINE_CLIP_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_SAME(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

/* hw/rtl/mscl_pkg.sv */
// ----------------------------------------------------------------------------
// mscl_pkg
// Shared types and constants of the midpoint subdivision line clipper.
// ----------------------------------------------------------------------------
package mscl_pkg;

   localparam int WIN_LEFT_RESET   = 150;
   localparam int WIN_RIGHT_RESET  = 450;
   localparam int WIN_TOP_RESET    = 100;
   localparam int WIN_BOTTOM_RESET = 400;

   localparam logic [1:0] REG_WIN_LEFT   = 2'd0;
   localparam logic [1:0] REG_WIN_RIGHT  = 2'd1;
   localparam logic [1:0] REG_WIN_TOP    = 2'd2;
   localparam logic [1:0] REG_WIN_BOTTOM = 2'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EVAL,
      ST_POP,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic load;
      logic pop;
      logic split;
      logic keep;
      logic set_ovf;
      logic out_mid;
      logic out_final;
   } cmd_type;

   typedef struct packed {
      logic visible;
      logic reject;
      logic tiny;
      logic stack_full;
      logic count_full;
      logic sp_zero;
   } status_type;

endpackage

/* hw/rtl/mscl_ctrl.sv */
// ----------------------------------------------------------------------------
// mscl_ctrl
// Sequencer: loads a segment, walks the subdivision stack, closes the output.
// ----------------------------------------------------------------------------
module mscl_ctrl
   import mscl_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (status.visible) begin
               if (status.count_full) begin
                  cmd.set_ovf = 1'b1;
               end else begin
                  cmd.keep    = 1'b1;
                  cmd.out_mid = 1'b1;
               end
               state_in = status.sp_zero ? ST_DONE : ST_POP;
            end else if (status.reject || status.tiny) begin
               state_in = status.sp_zero ? ST_DONE : ST_POP;
            end else if (status.stack_full) begin
               cmd.set_ovf = 1'b1;
               state_in    = status.sp_zero ? ST_DONE : ST_POP;
            end else begin
               // end-side half goes on the stack, start-side half is worked next
               cmd.split = 1'b1;
            end
         end
         ST_POP: begin
            cmd.pop  = 1'b1;
            state_in = ST_EVAL;
         end
         ST_DONE: begin
            cmd.out_final = 1'b1;
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

/* hw/rtl/mscl_datapath.sv */
// ----------------------------------------------------------------------------
// mscl_datapath
// Segment register, pending stack, outcodes, midpoint split, result registers.
// ----------------------------------------------------------------------------
module mscl_datapath
   import mscl_pkg::*;
#(
   parameter int COORD_BITS  = 12,
   parameter int STACK_DEPTH = 16,
   parameter int MAX_PIECES  = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  cmd_type                      cmd,
   output status_type                   status,
   input  logic signed [COORD_BITS-1:0] win_left,
   input  logic signed [COORD_BITS-1:0] win_right,
   input  logic signed [COORD_BITS-1:0] win_top,
   input  logic signed [COORD_BITS-1:0] win_bottom,
   input  logic signed [COORD_BITS-1:0] in_x0,
   input  logic signed [COORD_BITS-1:0] in_y0,
   input  logic signed [COORD_BITS-1:0] in_x1,
   input  logic signed [COORD_BITS-1:0] in_y1,
   output logic                         rsp_strobe,
   output logic signed [COORD_BITS-1:0] rsp_x0,
   output logic signed [COORD_BITS-1:0] rsp_y0,
   output logic signed [COORD_BITS-1:0] rsp_x1,
   output logic signed [COORD_BITS-1:0] rsp_y1,
   output logic                         rsp_empty,
   output logic                         rsp_ovf,
   output logic                         rsp_last
);

   localparam int CB  = COORD_BITS;
   localparam int SW  = 4 * CB;
   localparam int AW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int SPW = $clog2(STACK_DEPTH + 1);
   localparam int CNW = $clog2(MAX_PIECES + 1);

   logic [SW-1:0]  stack_mem [STACK_DEPTH];
   logic [SW-1:0]  cur_ff;
   logic [SPW-1:0] sp_ff;
   logic [CNW-1:0] count_ff;
   logic           ovf_ff;
   logic [SW-1:0]  held_ff;
   logic           held_ovf_ff;
   logic           held_valid_ff;

   logic           rsp_strobe_ff;
   logic [SW-1:0]  rsp_seg_ff;
   logic           rsp_empty_ff;
   logic           rsp_ovf_ff;
   logic           rsp_last_ff;

   logic signed [CB-1:0] cx0, cy0, cx1, cy1;
   logic signed [CB:0]   dx, dy, hx, hy, sx, sy;
   logic [CB-1:0]        mx, my;
   logic [3:0]           code0, code1;
   logic [SPW:0]         sp_plus2;
   logic [SPW-1:0]       sp_dec;
   logic [AW-1:0]        wr_addr, rd_addr;

   function automatic logic [3:0] outcode(input logic signed [CB-1:0] x,
                                          input logic signed [CB-1:0] y);
      logic [3:0] c;
      c    = 4'b0000;
      c[0] = (y <= win_top);
      c[1] = (y >= win_bottom);
      c[2] = (x >= win_right);
      c[3] = (x <= win_left);
      return c;
   endfunction

   assign cx0 = cur_ff[SW-1 -: CB];
   assign cy0 = cur_ff[3*CB-1 -: CB];
   assign cx1 = cur_ff[2*CB-1 -: CB];
   assign cy1 = cur_ff[CB-1:0];

   assign code0 = outcode(cx0, cy0);
   assign code1 = outcode(cx1, cy1);

   assign dx = {cx1[CB-1], cx1} - {cx0[CB-1], cx0};
   assign dy = {cy1[CB-1], cy1} - {cy0[CB-1], cy0};
   // halve with truncation toward zero
   assign hx = (dx + {{CB{1'b0}}, dx[CB]}) >>> 1;
   assign hy = (dy + {{CB{1'b0}}, dy[CB]}) >>> 1;
   assign sx = {cx0[CB-1], cx0} + hx;
   assign sy = {cy0[CB-1], cy0} + hy;
   assign mx = sx[CB-1:0];
   assign my = sy[CB-1:0];

   assign sp_plus2 = {1'b0, sp_ff} + (SPW + 1)'(2);
   assign sp_dec   = sp_ff - SPW'(1);
   assign wr_addr  = sp_ff[AW-1:0];
   assign rd_addr  = sp_dec[AW-1:0];

   always_comb begin
      status            = '0;
      status.visible    = ((code0 | code1) == 4'b0000);
      status.reject     = ((code0 & code1) != 4'b0000);
      status.tiny       = (dx >= -(CB + 1)'(1)) && (dx <= (CB + 1)'(1)) &&
                          (dy >= -(CB + 1)'(1)) && (dy <= (CB + 1)'(1));
      status.stack_full = (sp_plus2 > (SPW + 1)'(STACK_DEPTH));
      status.count_full = (count_ff >= CNW'(MAX_PIECES));
      status.sp_zero    = (sp_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (cmd.split) begin
         stack_mem[wr_addr] <= {mx, my, cx1, cy1};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cur_ff <= {in_x0, in_y0, in_x1, in_y1};
      end else if (cmd.pop) begin
         cur_ff <= stack_mem[rd_addr];
      end else if (cmd.split) begin
         cur_ff <= {cx0, cy0, mx, my};
      end
      if (cmd.keep) begin
         held_ff     <= cur_ff;
         held_ovf_ff <= ovf_ff;
      end
      if (cmd.out_mid || cmd.out_final) begin
         rsp_seg_ff <= held_valid_ff ? held_ff : '0;
      end
      rsp_empty_ff <= cmd.out_final && !held_valid_ff;
      rsp_ovf_ff   <= cmd.out_final ? ovf_ff : held_ovf_ff;
      rsp_last_ff  <= cmd.out_final;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sp_ff         <= '0;
         count_ff      <= '0;
         ovf_ff        <= 1'b0;
         held_valid_ff <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         if (cmd.load) begin
            sp_ff         <= '0;
            count_ff      <= '0;
            ovf_ff        <= 1'b0;
            held_valid_ff <= 1'b0;
         end else begin
            if (cmd.pop) begin
               sp_ff <= sp_dec;
            end else if (cmd.split) begin
               sp_ff <= sp_ff + SPW'(1);
            end
            if (cmd.keep) begin
               count_ff      <= count_ff + CNW'(1);
               held_valid_ff <= 1'b1;
            end
            if (cmd.set_ovf) begin
               ovf_ff <= 1'b1;
            end
         end
         rsp_strobe_ff <= cmd.out_final || (cmd.out_mid && held_valid_ff);
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_x0     = rsp_seg_ff[SW-1 -: CB];
   assign rsp_y0     = rsp_seg_ff[3*CB-1 -: CB];
   assign rsp_x1     = rsp_seg_ff[2*CB-1 -: CB];
   assign rsp_y1     = rsp_seg_ff[CB-1:0];
   assign rsp_empty  = rsp_empty_ff;
   assign rsp_ovf    = rsp_ovf_ff;
   assign rsp_last   = rsp_last_ff;

endmodule

/* hw/rtl/midpoint_subdivision_line_clip.sv */
// ----------------------------------------------------------------------------
// midpoint_subdivision_line_clip
// Clips a segment against a window by recursive midpoint halving.
//
// Input: pulse start with the endpoints on req_*; taken when busy is low.
// Busy stays high until the last result of the segment has been issued.
// Output: each visible piece, up to MAX_PIECES, is shown on rsp_* for one
// cycle with rsp_strobe; rsp_last marks the final piece. With nothing
// visible a single result comes with rsp_empty_res, zero coordinates
// and rsp_last. The receiver cannot stall; results are never held off.
// Sequence: a split pushes one half and keeps working the other; a pop goes
// through ST_POP, reading the stack into the segment register, then back
// to ST_EVAL. A piece appears only once the next one is found; the last
// one follows ST_DONE after the stack empties.
// Window registers sit on the APB port at byte offsets 0, 4, 8, 12
// (left, right, top, bottom). pready is always high.
// Reset: synchronous; window returns to 150, 450, 100, 400; block idles.
// ----------------------------------------------------------------------------
`include "midpoint_subdivision_line_clip_macros.svh"

module midpoint_subdivision_line_clip
   import mscl_pkg::*;
#(
   parameter int COORD_BITS  = 12,
   parameter int STACK_DEPTH = 16,
   parameter int MAX_PIECES  = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic signed [COORD_BITS-1:0] req_start_x,
   input  logic signed [COORD_BITS-1:0] req_start_y,
   input  logic signed [COORD_BITS-1:0] req_end_x,
   input  logic signed [COORD_BITS-1:0] req_end_y,
   output logic                         rsp_strobe,
   output logic signed [COORD_BITS-1:0] rsp_piece_x0,
   output logic signed [COORD_BITS-1:0] rsp_piece_y0,
   output logic signed [COORD_BITS-1:0] rsp_piece_x1,
   output logic signed [COORD_BITS-1:0] rsp_piece_y1,
   output logic                         rsp_empty_res,
   output logic                         rsp_overflow,
   output logic                         rsp_last,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [3:0]                   paddr,
   input  logic [31:0]                  pwdata,
   output logic [31:0]                  prdata,
   output logic                         pready
);

   localparam int CB = COORD_BITS;

   logic signed [CB-1:0] win_left_ff, win_right_ff, win_top_ff, win_bottom_ff;
   logic                 csr_wr;
   logic signed [CB-1:0] csr_wval;
   logic signed [CB-1:0] csr_rval;
   cmd_type              cmd;
   status_type           status;

   assign pready   = 1'b1;
   assign csr_wr   = psel && penable && pwrite;
   assign csr_wval = pwdata[CB-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         win_left_ff   <= CB'(WIN_LEFT_RESET);
         win_right_ff  <= CB'(WIN_RIGHT_RESET);
         win_top_ff    <= CB'(WIN_TOP_RESET);
         win_bottom_ff <= CB'(WIN_BOTTOM_RESET);
      end else if (csr_wr) begin
         case (paddr[3:2])
            REG_WIN_LEFT:   win_left_ff   <= csr_wval;
            REG_WIN_RIGHT:  win_right_ff  <= csr_wval;
            REG_WIN_TOP:    win_top_ff    <= csr_wval;
            REG_WIN_BOTTOM: win_bottom_ff <= csr_wval;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         REG_WIN_LEFT:   csr_rval = win_left_ff;
         REG_WIN_RIGHT:  csr_rval = win_right_ff;
         REG_WIN_TOP:    csr_rval = win_top_ff;
         REG_WIN_BOTTOM: csr_rval = win_bottom_ff;
         default:        csr_rval = '0;
      endcase
   end

   assign prdata = {{(32 - CB){csr_rval[CB-1]}}, csr_rval};

   mscl_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   mscl_datapath #(
      .COORD_BITS  (COORD_BITS),
      .STACK_DEPTH (STACK_DEPTH),
      .MAX_PIECES  (MAX_PIECES)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .win_left   (win_left_ff),
      .win_right  (win_right_ff),
      .win_top    (win_top_ff),
      .win_bottom (win_bottom_ff),
      .in_x0      (req_start_x),
      .in_y0      (req_start_y),
      .in_x1      (req_end_x),
      .in_y1      (req_end_y),
      .rsp_strobe (rsp_strobe),
      .rsp_x0     (rsp_piece_x0),
      .rsp_y0     (rsp_piece_y0),
      .rsp_x1     (rsp_piece_x1),
      .rsp_y1     (rsp_piece_y1),
      .rsp_empty  (rsp_empty_res),
      .rsp_ovf    (rsp_overflow),
      .rsp_last   (rsp_last)
   );

   // an empty result closes the transfer and carries zero coordinates
   `ASSERT_SAME(a_empty_is_last, clock, reset, rsp_strobe && rsp_empty_res, rsp_last)
   `ASSERT_SAME(a_empty_zero, clock, reset, rsp_strobe && rsp_empty_res, (rsp_piece_x0 == '0) && (rsp_piece_y1 == '0))
   // a piece that is not last means the segment is still being worked
   `ASSERT_SAME(a_more_pending, clock, reset, rsp_strobe && !rsp_last, busy)
   `ASSERT_NEXT(a_start_busy, clock, reset, start && !busy, busy && !rsp_strobe)

endmodule
